// ----- rtl/magcmp_pkg.sv -----
// ----------------------------------------------------------------------------
// magcmp_pkg - shared widths, register indexes and types
// Constants and types for the magnetometer offset and compass map block.
// ----------------------------------------------------------------------------
package magcmp_pkg;

	localparam int RAW_W  = 16;   // raw sample and calibration register width
	localparam int CORR_W = 17;   // corrected axis width
	localparam int POS_W  = 7;    // screen coordinate field width
	localparam int IDX_W  = 3;    // configuration index width

	// configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_MAX_X      = 3'd0,
		REG_MIN_X      = 3'd1,
		REG_MAX_Y      = 3'd2,
		REG_MIN_Y      = 3'd3,
		REG_MAX_Z      = 3'd4,
		REG_MIN_Z      = 3'd5,
		REG_CALIBRATED = 3'd6
	} cfg_reg_t;

	// axis numbering for per-axis arrays
	localparam int AX_X = 0;
	localparam int AX_Y = 1;
	localparam int AX_Z = 2;

endpackage

// ----- rtl/magnetometer_offset_and_compass_map.sv -----
// ----------------------------------------------------------------------------
// magnetometer_offset_and_compass_map - hard-iron correction and compass dot
// Subtracts per-axis offsets from a raw sample and maps corrected x and y to
// a clamped screen position through a pipelined long division.
// ----------------------------------------------------------------------------
// Usage:
//  - Sample channel: raw_x/raw_y/raw_z with sample_valid, block drives
//    sample_stall. A request is taken when sample_valid is high and
//    sample_stall low.
//  - Result channel: corrected axes, screen_x/screen_y and divide_fault with
//    result_valid; the receiver drives result_stall.
//  - Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; always
//    ready. Write only while no sample is in flight.
//  - A sample passes through s1-s4, QW division stages and the output register,
//    where QW = clog2(SCREEN_SPAN/2 + 1) is the number of division stages (one
//    quotient bit per stage).
//  - One sample per cycle is taken back to back while sample_stall is low; each stage holds one request.
//  - When the receiver stalls, requests collapse into empty stages behind the
//    output register, so input is only stalled once every stage is full.
//  - Reset clears all stage valid bits and loads each max register with 1,
//    each min register with -1 and clears calibrated.
// ----------------------------------------------------------------------------
module magnetometer_offset_and_compass_map #(
	parameter int DEFAULT_OFFSET_X = 0,
	parameter int DEFAULT_OFFSET_Y = 0,
	parameter int DEFAULT_OFFSET_Z = 0,
	parameter int SCREEN_CENTRE    = 60,
	parameter int SCREEN_SPAN      = 100
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// sample channel
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [magcmp_pkg::RAW_W-1:0]  raw_x,
	input  logic signed [magcmp_pkg::RAW_W-1:0]  raw_y,
	input  logic signed [magcmp_pkg::RAW_W-1:0]  raw_z,
	// result channel
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic signed [magcmp_pkg::CORR_W-1:0] corrected_x,
	output logic signed [magcmp_pkg::CORR_W-1:0] corrected_y,
	output logic signed [magcmp_pkg::CORR_W-1:0] corrected_z,
	output logic        [magcmp_pkg::POS_W-1:0]  screen_x,
	output logic        [magcmp_pkg::POS_W-1:0]  screen_y,
	output logic                                 divide_fault,
	// config channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic        [magcmp_pkg::IDX_W-1:0]  cfg_index,
	input  logic        [magcmp_pkg::RAW_W-1:0]  cfg_data
);

	localparam int RW = magcmp_pkg::RAW_W;
	localparam int CW = magcmp_pkg::CORR_W;
	localparam int H  = SCREEN_SPAN / 2;
	localparam int QW = $clog2(H + 1);                 // quotient bits / div stages
	localparam int NW = RW + QW;                       // numerator width
	localparam int PW = $clog2(SCREEN_CENTRE + H + 1) + 1;

	localparam logic signed [PW-1:0] C_S   = PW'(SCREEN_CENTRE);
	localparam logic signed [PW-1:0] LO_S  = PW'(SCREEN_CENTRE - H);
	localparam logic signed [PW-1:0] HI_S  = PW'(SCREEN_CENTRE + H);
	localparam logic        [QW-1:0] H_Q   = QW'(H);
	localparam logic        [NW-1:0] H_N   = NW'(H);

	// axis operand after sign split
	typedef struct packed {
		logic [CW-1:0] mag;    // |corrected|
		logic [RW-1:0] dmag;   // |divisor|
		logic          neg;    // position offset is negative
		logic          dz;     // divisor is zero
	} ax_t;

	// long division state
	typedef struct packed {
		logic [NW-1:0] rem;
		logic [RW-1:0] dmag;
		logic [QW-1:0] q;
		logic          neg;
		logic          dz;
		logic          sat;    // |t| >= H, clamps
	} axd_t;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic signed [RW-1:0] max_q [3];
	logic signed [RW-1:0] min_q [3];
	logic                 calibrated_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				max_q[a] <= RW'(1);
				min_q[a] <= '1;
			end
			calibrated_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				magcmp_pkg::REG_MAX_X:      max_q[magcmp_pkg::AX_X] <= cfg_data;
				magcmp_pkg::REG_MIN_X:      min_q[magcmp_pkg::AX_X] <= cfg_data;
				magcmp_pkg::REG_MAX_Y:      max_q[magcmp_pkg::AX_Y] <= cfg_data;
				magcmp_pkg::REG_MIN_Y:      min_q[magcmp_pkg::AX_Y] <= cfg_data;
				magcmp_pkg::REG_MAX_Z:      max_q[magcmp_pkg::AX_Z] <= cfg_data;
				magcmp_pkg::REG_MIN_Z:      min_q[magcmp_pkg::AX_Z] <= cfg_data;
				magcmp_pkg::REG_CALIBRATED: calibrated_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline registers
	// ------------------------------------------------------------------
	logic                 v_s1, v_s2, v_s3, v_s4, v_sf;
	logic signed [RW-1:0] raw_s1  [3];
	logic signed [CW-1:0] corr_s2 [3];
	logic signed [CW-1:0] corr_s3 [3];
	logic signed [CW-1:0] corr_s4 [3];
	logic signed [CW-1:0] corr_sf [3];
	ax_t                  ax_s3   [2];
	axd_t                 axd_s4  [2];
	logic signed [PW-1:0] pos_sf  [2];
	logic                 fault_sf;

	// division stages s5 .. s(4+QW), one quotient bit each
	logic                 v_sd    [QW];
	logic signed [CW-1:0] corr_sd [QW][3];
	axd_t                 axd_sd  [QW][2];

	// ------------------------------------------------------------------
	// Stage enables: a stage loads when empty or when its successor moves
	// ------------------------------------------------------------------
	logic en_s1, en_s2, en_s3, en_s4, en_sf;
	logic en_sd [QW];

	always_comb begin
		en_sf = !v_sf || !result_stall;
		en_sd[QW-1] = !v_sd[QW-1] || en_sf;
		for (int k = QW - 2; k >= 0; k--) begin
			en_sd[k] = !v_sd[k] || en_sd[k+1];
		end
		en_s4 = !v_s4 || en_sd[0];
		en_s3 = !v_s3 || en_s4;
		en_s2 = !v_s2 || en_s3;
		en_s1 = !v_s1 || en_s2;
	end

	assign sample_stall = !en_s1;

	// ------------------------------------------------------------------
	// Valid bits
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_sf <= 1'b0;
			for (int k = 0; k < QW; k++) begin
				v_sd[k] <= 1'b0;
			end
		end else begin
			if (en_s1) v_s1 <= sample_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
			if (en_sd[0]) v_sd[0] <= v_s4;
			for (int k = 1; k < QW; k++) begin
				if (en_sd[k]) v_sd[k] <= v_sd[k-1];
			end
			if (en_sf) v_sf <= v_sd[QW-1];
		end
	end

	// ------------------------------------------------------------------
	// s1: capture raw sample
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en_s1) begin
			raw_s1[magcmp_pkg::AX_X] <= raw_x;
			raw_s1[magcmp_pkg::AX_Y] <= raw_y;
			raw_s1[magcmp_pkg::AX_Z] <= raw_z;
		end
	end

	// ------------------------------------------------------------------
	// s2: hard-iron offset and subtraction
	// ------------------------------------------------------------------
	logic signed [RW-1:0] dflt_off [3];
	logic signed [CW-1:0] ext_sum  [3];
	logic signed [CW-1:0] mid_sum  [3];
	logic signed [RW-1:0] off      [3];
	logic signed [CW-1:0] corr_nx  [3];

	assign dflt_off[magcmp_pkg::AX_X] = RW'(DEFAULT_OFFSET_X);
	assign dflt_off[magcmp_pkg::AX_Y] = RW'(DEFAULT_OFFSET_Y);
	assign dflt_off[magcmp_pkg::AX_Z] = RW'(DEFAULT_OFFSET_Z);

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			ext_sum[a] = CW'(max_q[a]) + CW'(min_q[a]);
			// halve, truncating toward zero
			mid_sum[a] = ext_sum[a] + CW'(ext_sum[a][CW-1]);
			off[a]     = calibrated_q ? mid_sum[a][CW-1:1] : dflt_off[a];
			corr_nx[a] = CW'(raw_s1[a]) - CW'(off[a]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) corr_s2 <= corr_nx;
	end

	// ------------------------------------------------------------------
	// s3: divisor select and magnitudes
	// axis 0 (x) drives screen_y, axis 1 (y) drives screen_x
	// ------------------------------------------------------------------
	ax_t                  ax_nx [2];
	logic signed [RW-1:0] dsel  [2];

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			dsel[a]        = corr_s2[a][CW-1] ? min_q[a] : max_q[a];
			ax_nx[a].dz    = (dsel[a] == '0);
			ax_nx[a].dmag  = dsel[a][RW-1] ? RW'(-dsel[a]) : RW'(dsel[a]);
			ax_nx[a].mag   = corr_s2[a][CW-1] ? CW'(-corr_s2[a]) : CW'(corr_s2[a]);
		end
		// floor of the signed offset; sign depends only on the divisor sign
		ax_nx[0].neg = !dsel[0][RW-1];
		ax_nx[1].neg = dsel[1][RW-1];
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			corr_s3 <= corr_s2;
			ax_s3   <= ax_nx;
		end
	end

	// ------------------------------------------------------------------
	// s4: scale numerator, saturation test
	// ------------------------------------------------------------------
	axd_t axd_nx [2];

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			axd_nx[a].rem  = H_N * NW'(ax_s3[a].mag[RW-1:0]);
			axd_nx[a].dmag = ax_s3[a].dmag;
			axd_nx[a].q    = '0;
			axd_nx[a].neg  = ax_s3[a].neg;
			axd_nx[a].dz   = ax_s3[a].dz;
			axd_nx[a].sat  = (ax_s3[a].mag >= CW'(ax_s3[a].dmag));
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			corr_s4 <= corr_s3;
			axd_s4  <= axd_nx;
		end
	end

	// ------------------------------------------------------------------
	// Division stages: restoring step for quotient bit QW-1-k
	// ------------------------------------------------------------------
	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int BIT = QW - 1 - k;
		axd_t                 src  [2];
		logic signed [CW-1:0] csrc [3];
		axd_t                 nxt  [2];
		logic        [NW-1:0] sh   [2];

		if (k == 0) begin : g_first
			assign src  = axd_s4;
			assign csrc = corr_s4;
		end else begin : g_next
			assign src  = axd_sd[k-1];
			assign csrc = corr_sd[k-1];
		end

		always_comb begin
			for (int a = 0; a < 2; a++) begin
				nxt[a] = src[a];
				sh[a]  = NW'(src[a].dmag) << BIT;
				if (src[a].rem >= sh[a]) begin
					nxt[a].rem    = src[a].rem - sh[a];
					nxt[a].q[BIT] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en_sd[k]) begin
				axd_sd[k]  <= nxt;
				corr_sd[k] <= csrc;
			end
		end
	end

	// ------------------------------------------------------------------
	// Final stage: rounding, clamp, fault
	// ------------------------------------------------------------------
	logic signed [PW-1:0] pos_nx [2];
	logic        [QW:0]   qr     [2];

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			qr[a] = (QW+1)'(axd_sd[QW-1][a].q) + (QW+1)'(axd_sd[QW-1][a].rem != '0);
			if (axd_sd[QW-1][a].dz) begin
				pos_nx[a] = C_S;
			end else if (axd_sd[QW-1][a].sat) begin
				pos_nx[a] = axd_sd[QW-1][a].neg ? LO_S : HI_S;
			end else if (axd_sd[QW-1][a].neg) begin
				pos_nx[a] = C_S - PW'(qr[a]);
			end else begin
				pos_nx[a] = C_S + PW'(axd_sd[QW-1][a].q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_sf) begin
			corr_sf  <= corr_sd[QW-1];
			pos_sf   <= pos_nx;
			fault_sf <= axd_sd[QW-1][0].dz | axd_sd[QW-1][1].dz;
		end
	end

	// ------------------------------------------------------------------
	// Outputs
	// ------------------------------------------------------------------
	assign result_valid = v_sf;
	assign corrected_x  = corr_sf[magcmp_pkg::AX_X];
	assign corrected_y  = corr_sf[magcmp_pkg::AX_Y];
	assign corrected_z  = corr_sf[magcmp_pkg::AX_Z];
	assign screen_y     = pos_sf[0][magcmp_pkg::POS_W-1:0];
	assign screen_x     = pos_sf[1][magcmp_pkg::POS_W-1:0];
	assign divide_fault = fault_sf;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// input only stalls behind a full first stage
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> v_s1)
		else $error("sample stalled with empty first stage");

	// a zero divisor leaves at least one coordinate at the centre
	a_fault_centre: assert property (@(posedge clk) disable iff (!arst_n)
		(v_sf && fault_sf) |-> (pos_sf[0] == C_S || pos_sf[1] == C_S))
		else $error("divide fault without centred coordinate");

	// positions stay inside the clamp window
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_sf |-> (pos_sf[0] >= LO_S && pos_sf[0] <= HI_S &&
		          pos_sf[1] >= LO_S && pos_sf[1] <= HI_S))
		else $error("screen position outside clamp window");

	// the unsaturated x quotient with a nonzero divisor stays below the half span
	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(v_sd[QW-1] && !axd_sd[QW-1][0].sat && !axd_sd[QW-1][0].dz)
		|-> (axd_sd[QW-1][0].q < H_Q))
		else $error("x quotient exceeds half span");

	// result advances into an empty output stage
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(v_sd[QW-1] && !v_sf) |=> v_sf)
		else $error("result lost entering output stage");

endmodule
